FILE: design/rocket_flight_event_sequencer_top_defines.svh
// Assertion macros used by the flight event sequencer top level.
`ifndef ROCKET_FLIGHT_EVENT_SEQUENCER_TOP_DEFINES_SVH
`define ROCKET_FLIGHT_EVENT_SEQUENCER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rfes_pkg.sv
`timescale 1ns / 1ps
// Constants and codes shared by the flight event sequencer.
package rfes_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IMPULSE_W  = 48;
    localparam int SQ_W       = 47;
    localparam int VSQ_W      = 49;
    localparam int AGL_W      = 26;

    typedef logic [1:0] phase_t;

    // Motor phase codes.
    localparam phase_t MOTOR_PENDING = 2'd0;
    localparam phase_t MOTOR_BURNING = 2'd1;
    localparam phase_t MOTOR_BURNOUT = 2'd2;

    // Parachute phase codes.
    localparam phase_t CHUTE_NONE   = 2'd0;
    localparam phase_t CHUTE_DROGUE = 2'd1;
    localparam phase_t CHUTE_MAIN   = 2'd2;

    // Termination causes.
    localparam logic [1:0] END_CONTINUE = 2'd0;
    localparam logic [1:0] END_DIVERGED = 2'd1;
    localparam logic [1:0] END_LANDED   = 2'd2;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] REG_IGNITION_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_ALT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIFTOFF_ALT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TERRAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUAL_DEPLOY   = 3'd5;

    // Limits, all in the block's fixed-point units.
    localparam logic [VSQ_W-1:0]         SPEED_LIMIT_SQ = 49'd1000000000000;
    localparam logic signed [24:0]       ALT_LIMIT      = 25'sd10000000;
    localparam logic signed [AGL_W-1:0]  LANDED_AGL     = 26'sd500;
    localparam logic [IMPULSE_W-1:0]     IMPULSE_MAX    = {IMPULSE_W{1'b1}};

endpackage

FILE: design/rocket_flight_event_sequencer_top.sv
`timescale 1ns / 1ps
// Top level of the flight event sequencer: sample register, event logic and result register.
//
//  Channel | Direction | Handshake           | Content
//  --------+-----------+---------------------+------------------------------------------
//  in      | sink      | in_valid, in_stall  | one flight sample per transaction
//  out     | source    | out_valid, out_stall| one event and status result per transaction
//  cfg     | sink      | cfg_we              | register index and data, write only
//
// An accepted sample passes through the sample register into the result register, and one
// sample can be accepted every cycle while the result is not stalled. The velocity squares
// are formed on the way into the sample register; the impulse multiply-accumulate, the
// phase machines and the speed compare sit between the sample and result registers.
// Reset clears the flight state, the pipeline valids and sets the register defaults.
// A stalled result holds the result register, and a new sample is still taken while
// the sample register is empty.

`include "rocket_flight_event_sequencer_top_defines.svh"

module rocket_flight_event_sequencer_top
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [rfes_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfes_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [31:0]                         sim_time_us,
    input  logic [19:0]                         thrust,
    input  logic signed [24:0]                  altitude_asl,
    input  logic signed [23:0]                  vel_north,
    input  logic signed [23:0]                  vel_east,
    input  logic signed [23:0]                  vel_down,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                ignite_cmd,
    output logic                                shutdown_cmd,
    output logic                                drogue_cmd,
    output logic                                main_cmd,
    output logic [1:0]                          motor_phase_out,
    output logic [1:0]                          chute_phase_out,
    output logic                                liftoff_seen,
    output logic                                apogee_seen,
    output logic [1:0]                          end_cause,
    output logic [47:0]                         impulse_total,
    output logic [31:0]                         burn_time_us
);

    import rfes_pkg::*;

    // Configuration registers.
    logic [31:0]        ignition_time_reg;
    logic [19:0]        shutdown_thrust_reg;
    logic [23:0]        main_deploy_alt_reg;
    logic [23:0]        liftoff_alt_reg;
    logic signed [24:0] terrain_reg;
    logic               dual_deploy_reg;

    // Flight state.
    phase_t                 motor_phase_reg, motor_phase_next;
    phase_t                 chute_phase_reg, chute_phase_next;
    logic                   liftoff_reg, liftoff_next;
    logic                   apogee_reg, apogee_next;
    logic [31:0]            prev_time_reg, prev_time_next;
    logic [IMPULSE_W-1:0]   impulse_reg, impulse_next;
    logic [31:0]            burn_end_reg, burn_end_next;

    // Sample register.
    logic                   s1_valid_reg;
    logic [31:0]            s1_time_reg;
    logic [19:0]            s1_thrust_reg;
    logic signed [24:0]     s1_alt_reg;
    logic signed [23:0]     s1_vd_reg;
    logic [SQ_W-1:0]        s1_sqn_reg, s1_sqe_reg, s1_sqd_reg;

    // Result register.
    logic                   out_valid_reg;
    logic                   ign_reg, shd_reg, drg_reg, mn_reg;
    phase_t                 motor_out_reg, chute_out_reg;
    logic                   liftoff_out_reg, apogee_out_reg;
    logic [1:0]             end_reg;
    logic [IMPULSE_W-1:0]   impulse_out_reg;
    logic [31:0]            btime_reg;

    // Event logic outputs.
    logic                   ign_next, shd_next, drg_next, mn_next;
    logic [1:0]             end_next;
    logic [31:0]            btime_next;

    logic                   advance;
    logic                   in_accept;
    logic                   s1_fire;
    logic signed [47:0]     sqn_full, sqe_full, sqd_full;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign s1_fire   = s1_valid_reg && advance;

    assign sqn_full = vel_north * vel_north;
    assign sqe_full = vel_east * vel_east;
    assign sqd_full = vel_down * vel_down;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignition_time_reg   <= '0;
            shutdown_thrust_reg <= 20'd100;
            main_deploy_alt_reg <= 24'd55000;
            liftoff_alt_reg     <= 24'd1000;
            terrain_reg         <= '0;
            dual_deploy_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IGNITION_TIME: ignition_time_reg   <= cfg_data;
                REG_SHUTDOWN_THR:  shutdown_thrust_reg <= cfg_data[19:0];
                REG_MAIN_ALT:      main_deploy_alt_reg <= cfg_data[23:0];
                REG_LIFTOFF_ALT:   liftoff_alt_reg     <= cfg_data[23:0];
                REG_TERRAIN:       terrain_reg         <= $signed(cfg_data[24:0]);
                REG_DUAL_DEPLOY:   dual_deploy_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance || !s1_valid_reg)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_time_reg   <= sim_time_us;
            s1_thrust_reg <= thrust;
            s1_alt_reg    <= altitude_asl;
            s1_vd_reg     <= vel_down;
            s1_sqn_reg    <= sqn_full[SQ_W-1:0];
            s1_sqe_reg    <= sqe_full[SQ_W-1:0];
            s1_sqd_reg    <= sqd_full[SQ_W-1:0];
        end
    end

    always_comb
    begin
        logic signed [AGL_W-1:0] agl;
        logic [VSQ_W-1:0]        vsq;
        logic [31:0]             dt;
        logic [51:0]             inc;
        logic [52:0]             sum;
        logic                    diverged;

        agl = 26'(s1_alt_reg) - 26'(terrain_reg);
        vsq = VSQ_W'(s1_sqn_reg) + VSQ_W'(s1_sqe_reg) + VSQ_W'(s1_sqd_reg);
        dt  = s1_time_reg - prev_time_reg;
        inc = 52'(s1_thrust_reg) * 52'(dt);
        sum = 53'(impulse_reg) + 53'(inc);

        ign_next         = 1'b0;
        shd_next         = 1'b0;
        drg_next         = 1'b0;
        mn_next          = 1'b0;
        end_next         = END_CONTINUE;
        motor_phase_next = motor_phase_reg;
        chute_phase_next = chute_phase_reg;
        liftoff_next     = liftoff_reg;
        impulse_next     = impulse_reg;
        burn_end_next    = burn_end_reg;
        prev_time_next   = prev_time_reg;

        // Apogee looks at the motor phase held before this sample.
        apogee_next = apogee_reg
                    || (motor_phase_reg[1] && (s1_vd_reg > 24'sd0));

        unique case (motor_phase_reg)
            MOTOR_PENDING:
            begin
                if (s1_time_reg >= ignition_time_reg)
                begin
                    ign_next         = 1'b1;
                    motor_phase_next = MOTOR_BURNING;
                end
            end
            MOTOR_BURNING:
            begin
                if (s1_time_reg > prev_time_reg)
                begin
                    impulse_next = (sum[52:IMPULSE_W] != '0) ? IMPULSE_MAX
                                                             : sum[IMPULSE_W-1:0];
                end
                if (s1_thrust_reg < shutdown_thrust_reg)
                begin
                    shd_next         = 1'b1;
                    burn_end_next    = s1_time_reg;
                    motor_phase_next = MOTOR_BURNOUT;
                end
            end
            default:
            begin
            end
        endcase

        if (apogee_next && (chute_phase_reg == CHUTE_NONE))
        begin
            if (dual_deploy_reg)
            begin
                drg_next         = 1'b1;
                chute_phase_next = CHUTE_DROGUE;
            end
            else
            begin
                mn_next          = 1'b1;
                chute_phase_next = CHUTE_MAIN;
            end
        end
        // The main may open in the same transaction as the drogue.
        if ((chute_phase_next == CHUTE_DROGUE)
            && (agl < $signed({2'b00, main_deploy_alt_reg})))
        begin
            mn_next          = 1'b1;
            chute_phase_next = CHUTE_MAIN;
        end

        diverged = (vsq > SPEED_LIMIT_SQ) || (s1_alt_reg > ALT_LIMIT);
        if (diverged)
        begin
            end_next = END_DIVERGED;
        end
        else
        begin
            if ((vsq != '0) && (agl > $signed({2'b00, liftoff_alt_reg})))
            begin
                liftoff_next = 1'b1;
            end
            if (liftoff_next && apogee_next && (agl < LANDED_AGL))
            begin
                end_next = END_LANDED;
            end
            else
            begin
                prev_time_next = s1_time_reg;
            end
        end

        btime_next = motor_phase_next[1] ? (burn_end_next - ignition_time_reg) : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_phase_reg <= MOTOR_PENDING;
            chute_phase_reg <= CHUTE_NONE;
            liftoff_reg     <= 1'b0;
            apogee_reg      <= 1'b0;
            prev_time_reg   <= '0;
            impulse_reg     <= '0;
            burn_end_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                motor_phase_reg <= motor_phase_next;
                chute_phase_reg <= chute_phase_next;
                liftoff_reg     <= liftoff_next;
                apogee_reg      <= apogee_next;
                prev_time_reg   <= prev_time_next;
                impulse_reg     <= impulse_next;
                burn_end_reg    <= burn_end_next;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            ign_reg         <= ign_next;
            shd_reg         <= shd_next;
            drg_reg         <= drg_next;
            mn_reg          <= mn_next;
            motor_out_reg   <= motor_phase_next;
            chute_out_reg   <= chute_phase_next;
            liftoff_out_reg <= liftoff_next;
            apogee_out_reg  <= apogee_next;
            end_reg         <= end_next;
            impulse_out_reg <= impulse_next;
            btime_reg       <= btime_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ignite_cmd      = ign_reg;
    assign shutdown_cmd    = shd_reg;
    assign drogue_cmd      = drg_reg;
    assign main_cmd        = mn_reg;
    assign motor_phase_out = motor_out_reg;
    assign chute_phase_out = chute_out_reg;
    assign liftoff_seen    = liftoff_out_reg;
    assign apogee_seen     = apogee_out_reg;
    assign end_cause       = end_reg;
    assign impulse_total   = impulse_out_reg;
    assign burn_time_us    = btime_reg;

    `RFES_ASSERT_NEXT(a_motor_no_return, motor_phase_reg != MOTOR_PENDING,
        motor_phase_reg != MOTOR_PENDING, "motor phase returned to pending")
    `RFES_ASSERT_NEXT(a_impulse_monotonic, 1'b1,
        impulse_reg >= $past(impulse_reg), "impulse decreased")
    `RFES_ASSERT_NOW(a_main_phase, out_valid && main_cmd,
        chute_phase_out == CHUTE_MAIN, "main command without main descent")
    `RFES_ASSERT_NOW(a_shutdown_phase, out_valid && shutdown_cmd,
        motor_phase_out == MOTOR_BURNOUT, "shutdown command without burnout")
    `RFES_ASSERT_NOW(a_stall_needs_sample, in_stall,
        s1_valid_reg && out_valid_reg, "input stalled with free space")

endmodule
